// File: sv/ephemeral_port_allocator_macros.svh
// ----------------------------------------------------------------------------
// ephemeral port allocator assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef EPHEMERAL_PORT_ALLOCATOR_MACROS_SVH
`define EPHEMERAL_PORT_ALLOCATOR_MACROS_SVH

// property holds at every rising edge of clk_i
`define EPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define EPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/epa_pkg.sv
// ----------------------------------------------------------------------------
// epa_pkg
// shared constants, types and state encoding of the port allocator
// ----------------------------------------------------------------------------
package epa_pkg;

  localparam int unsigned PORT_W        = 16;
  localparam int unsigned CNT_W         = 14;
  localparam int unsigned NUM_SLOTS_DEF = 8;

  localparam logic [PORT_W-1:0] PORT_BASE = 16'hC000;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PUSH
  } epa_state_e;

  // result of one slot compare, in the cycle after the read
  typedef struct packed {
    logic vld;
    logic hit;
    logic empty;
  } epa_scan_t;

  // finished result handed to the output register
  typedef struct packed {
    logic              vld;
    logic [PORT_W-1:0] port;
    logic              full;
  } epa_done_t;

endpackage

// File: sv/ephemeral_port_allocator.sv
// ----------------------------------------------------------------------------
// ephemeral_port_allocator
// hands out ephemeral ports from 0xC000 up and frees them on request
// ----------------------------------------------------------------------------
// Usage: one input beat per request on s_axis. tuser selects allocate (0) or
// release (1); tdata carries the port to release. Each request returns one
// beat on m_axis: tdata is the new port (0 on release or when the table is
// full), tuser is the table-full flag.
// Timing: the sequencer sweeps the slot memory through one read port and one
// shared comparator, one slot per cycle, once for each candidate. Each
// duplicate found starts a new sweep with the next candidate, up to NUM_SLOTS
// retries. s_axis_tready is low while a request is in work, so a new request
// is taken only once the previous one has left for the output register.
// The result sits in an output register; if the receiver stalls, the block
// holds the finished result and stays busy until the register frees up.
// cfg_we_i loads cfg_wdata_i into the candidate counter; write it when idle.
// Reset empties every slot and clears the counter to zero.
// ----------------------------------------------------------------------------
module ephemeral_port_allocator import epa_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [15:0]       s_axis_tdata_i,  // [15:0] port_to_release
  input  logic              s_axis_tuser_i,  // [0] kind
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [15:0]       m_axis_tdata_o,  // [15:0] allocated_port
  output logic              m_axis_tuser_o,  // [0] table_full
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [PORT_W-1:0] key;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic              clr_en;
  logic [IW-1:0]     clr_addr;
  epa_scan_t         scan;
  logic [IW-1:0]     scan_idx;
  epa_done_t         done;
  logic              out_free;

  logic              m_vld_q;
  logic [PORT_W-1:0] m_data_q;
  logic              m_user_q;

  epa_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_kind_i   (s_axis_tuser_i),
    .in_port_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .key_o       (key),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .clr_en_o    (clr_en),
    .clr_addr_o  (clr_addr),
    .scan_i      (scan),
    .scan_idx_i  (scan_idx),
    .done_o      (done),
    .out_free_i  (out_free)
  );

  epa_slot_store #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .key_i      (key),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (key),
    .clr_en_i   (clr_en),
    .clr_addr_i (clr_addr),
    .scan_o     (scan),
    .scan_idx_o (scan_idx)
  );

  assign out_free = !m_vld_q || m_axis_tready_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (out_free) begin
      m_vld_q <= done.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && done.vld) begin
      m_data_q <= done.port;
      m_user_q <= done.full;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

// File: sv/epa_slot_store.sv
// ----------------------------------------------------------------------------
// epa_slot_store
// slot memory with per-slot valid bits and the shared key comparator
// ----------------------------------------------------------------------------
module epa_slot_store import epa_pkg::*; #(
  parameter int unsigned  NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int unsigned IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [IW-1:0]     rd_addr_i,
  input  logic [PORT_W-1:0] key_i,
  input  logic              wr_en_i,
  input  logic [IW-1:0]     wr_addr_i,
  input  logic [PORT_W-1:0] wr_data_i,
  input  logic              clr_en_i,
  input  logic [IW-1:0]     clr_addr_i,
  output epa_scan_t         scan_o,
  output logic [IW-1:0]     scan_idx_o
);

  logic [PORT_W-1:0]    mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_q;
  logic [PORT_W-1:0]    rdata_q;
  logic [IW-1:0]        rd_addr_q;
  logic                 rd_vld_q;
  logic [PORT_W-1:0]    slot_val;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      rd_vld_q <= rd_en_i;
      if (rd_en_i) begin
        rd_addr_q <= rd_addr_i;
      end
      if (clr_en_i) begin
        valid_q[clr_addr_i] <= 1'b0;
      end
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  // an empty slot reads as zero
  assign slot_val     = valid_q[rd_addr_q] ? rdata_q : '0;
  assign scan_o.vld   = rd_vld_q;
  assign scan_o.hit   = (slot_val == key_i);
  assign scan_o.empty = (slot_val == '0);
  assign scan_idx_o   = rd_addr_q;

endmodule

// File: sv/epa_ctrl.sv
// ----------------------------------------------------------------------------
// epa_ctrl
// sequencer: candidate counter, slot sweep, retry and result decision
// ----------------------------------------------------------------------------
module epa_ctrl import epa_pkg::*; #(
  parameter int unsigned  NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int unsigned IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int unsigned CW        = $clog2(NUM_SLOTS + 2)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_kind_i,
  input  logic [PORT_W-1:0] in_port_i,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  output logic              rd_en_o,
  output logic [IW-1:0]     rd_addr_o,
  output logic [PORT_W-1:0] key_o,
  output logic              wr_en_o,
  output logic [IW-1:0]     wr_addr_o,
  output logic              clr_en_o,
  output logic [IW-1:0]     clr_addr_o,
  input  epa_scan_t         scan_i,
  input  logic [IW-1:0]     scan_idx_i,
  output epa_done_t         done_o,
  input  logic              out_free_i
);

  epa_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PORT_W-1:0] key_q, key_d;
  logic              rel_q, rel_d;
  logic [CW-1:0]     tries_q, tries_d;
  logic [CW-1:0]     issue_q, issue_d;
  logic              dup_q, dup_d;
  logic              emp_q, emp_d;
  logic [IW-1:0]     emp_idx_q, emp_idx_d;
  logic [PORT_W-1:0] res_port_q, res_port_d;
  logic              res_full_q, res_full_d;

  logic              accept;
  logic              last;
  logic              dup_now;
  logic              emp_now;
  logic [IW-1:0]     emp_idx_now;
  logic              retry;
  logic              finish;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign last        = (state_q == S_SCAN) && scan_i.vld && (scan_idx_i == IW'(NUM_SLOTS - 1));
  assign dup_now     = dup_q || (scan_i.vld && scan_i.hit);
  assign emp_now     = emp_q || (scan_i.vld && scan_i.empty);
  assign emp_idx_now = emp_q ? emp_idx_q : scan_idx_i;
  assign retry       = last && !rel_q && dup_now && (tries_q != CW'(NUM_SLOTS + 1));
  assign finish      = last && !retry;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (finish) state_d = S_PUSH;
      end
      S_PUSH: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = (state_q == S_IDLE);
    rd_en_o      = (state_q == S_SCAN) && (issue_q < CW'(NUM_SLOTS));
    rd_addr_o    = issue_q[IW-1:0];
    key_o        = key_q;
    wr_en_o      = finish && !rel_q && emp_now;
    wr_addr_o    = emp_idx_now;
    clr_en_o     = (state_q == S_SCAN) && rel_q && scan_i.vld && scan_i.hit;
    clr_addr_o   = scan_idx_i;
    done_o.vld   = (state_q == S_PUSH);
    done_o.port  = res_port_q;
    done_o.full  = res_full_q;
  end

  // datapath
  always_comb begin
    cnt_d      = cnt_q;
    key_d      = key_q;
    rel_d      = rel_q;
    tries_d    = tries_q;
    issue_d    = issue_q;
    dup_d      = dup_q;
    emp_d      = emp_q;
    emp_idx_d  = emp_idx_q;
    res_port_d = res_port_q;
    res_full_d = res_full_q;
    if (rd_en_o) begin
      issue_d = issue_q + CW'(1);
    end
    if (state_q == S_SCAN && scan_i.vld) begin
      dup_d = dup_now;
      if (!emp_q && scan_i.empty) begin
        emp_d     = 1'b1;
        emp_idx_d = scan_idx_i;
      end
    end
    if (accept || retry) begin
      issue_d = '0;
      dup_d   = 1'b0;
      emp_d   = 1'b0;
    end
    if (accept) begin
      rel_d = (in_kind_i == KIND_RELEASE);
      if (in_kind_i == KIND_RELEASE) begin
        key_d = in_port_i;
      end else begin
        key_d   = PORT_BASE | {{(PORT_W-CNT_W){1'b0}}, cnt_q};
        cnt_d   = cnt_q + CNT_W'(1);
        tries_d = CW'(1);
      end
    end
    if (retry) begin
      key_d   = PORT_BASE | {{(PORT_W-CNT_W){1'b0}}, cnt_q};
      cnt_d   = cnt_q + CNT_W'(1);
      tries_d = tries_q + CW'(1);
    end
    if (finish) begin
      res_port_d = (!rel_q && emp_now) ? key_q : '0;
      res_full_d = !rel_q && !emp_now;
    end
    if (cfg_we_i) begin
      cnt_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      rel_q      <= 1'b0;
      tries_q    <= '0;
      issue_q    <= '0;
      dup_q      <= 1'b0;
      emp_q      <= 1'b0;
      emp_idx_q  <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rel_q      <= rel_d;
      tries_q    <= tries_d;
      issue_q    <= issue_d;
      dup_q      <= dup_d;
      emp_q      <= emp_d;
      emp_idx_q  <= emp_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    res_port_q <= res_port_d;
    res_full_q <= res_full_d;
  end

endmodule

// File: sv/epa_checker.sv
// ----------------------------------------------------------------------------
// epa_checker
// port-level checks of the port allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "ephemeral_port_allocator_macros.svh"

module epa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // a held result beat stays put until taken
  `EPA_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result beat dropped or changed under stall")

  // a full table never reports a port
  `EPA_ASSERT(a_full_zero, (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 16'h0000), "full flag with nonzero port")

  // any returned port lies in the ephemeral range
  `EPA_ASSERT(a_port_range, (m_axis_tvalid_o && (m_axis_tdata_o != 16'h0000)) |-> (m_axis_tdata_o[15:14] == 2'b11), "port outside ephemeral range")

  // one request at a time: busy right after an accepted beat
  `EPA_ASSERT_NEXT(a_busy, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "ready right after accept")

endmodule

bind ephemeral_port_allocator epa_checker u_epa_checker (.*);

// File: dv/tb_ephemeral_port_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ephemeral_port_allocator
// self-checking bench for the ephemeral port allocator: a directed table of
// allocate, release and counter loads walks the full table, the duplicate
// retry chain and counter wrap, then random segments keep the slot table
// churning under four idling modes, each beat scored by a port table shadow
// ----------------------------------------------------------------------------
module tb_ephemeral_port_allocator;
  import epa_pkg::*;

  localparam int unsigned NUM_SLOTS  = NUM_SLOTS_DEF;
  localparam int          SEGMENTS   = 48;
  localparam int          SEG_BEATS  = 31;
  localparam int          STALL_MAX  = 4000;
  localparam int          TAIL_WAIT  = 100;

  typedef enum logic { ROW_BEAT, ROW_LOAD } row_e;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic              full;
  } port_result_t;

  typedef struct packed {
    row_e              what;
    logic              kind;
    logic [PORT_W-1:0] port;
    logic [CNT_W-1:0]  seed;
    logic              typed;
    logic [PORT_W-1:0] exp_port;
    logic              exp_full;
  } stim_row_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              s_valid        = 1'b0;
  logic [15:0]       s_tdata        = '0;
  logic              s_tuser        = 1'b0;
  logic              m_ready        = 1'b0;
  logic              cfg_we         = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata      = '0;
  logic              s_axis_tready_o;
  logic              m_axis_tvalid_o;
  logic [15:0]       m_axis_tdata_o;
  logic              m_axis_tuser_o;

  // shadow of the slot table and candidate counter
  logic [PORT_W-1:0] port_tab [NUM_SLOTS];
  logic [CNT_W-1:0]  cand_count;
  port_result_t      awaited_ports [$];
  stim_row_t         directed_rows [$];
  idle_mode_e        idle_mode = IDLE_NONE;
  int                mismatches = 0;
  int                quiet_cycles = 0;
  port_result_t      got_result;

  ephemeral_port_allocator #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic port_result_t next_port_result(logic kind, logic [PORT_W-1:0] rel_port);
    port_result_t      r;
    logic [PORT_W-1:0] cand;
    bit                dup;
    bit                placed;
    r      = '0;
    cand   = '0;
    placed = 1'b0;
    if (kind == KIND_ALLOC) begin
      for (int t = 0; t < NUM_SLOTS + 1; t++) begin
        cand       = PORT_BASE | {2'b00, cand_count};
        cand_count = cand_count + 1'b1;
        dup        = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (port_tab[i] == cand) dup = 1'b1;
        end
        if (!dup) break;
      end
      r.full = 1'b1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!placed && port_tab[i] == '0) begin
          port_tab[i] = cand;
          r.port      = cand;
          r.full      = 1'b0;
          placed      = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (port_tab[i] == rel_port) port_tab[i] = '0;
      end
    end
    return r;
  endfunction

  function automatic stim_row_t mk_row(row_e what, logic kind, logic [PORT_W-1:0] port,
                                       logic [CNT_W-1:0] seed, logic typed,
                                       logic [PORT_W-1:0] exp_port, logic exp_full);
    stim_row_t r;
    r.what     = what;
    r.kind     = kind;
    r.port     = port;
    r.seed     = seed;
    r.typed    = typed;
    r.exp_port = exp_port;
    r.exp_full = exp_full;
    return r;
  endfunction

  function automatic int idle_pct(bit sender);
    case (idle_mode)
      IDLE_SENDER:   return sender ? 84 : 0;
      IDLE_RECEIVER: return sender ? 0 : 84;
      IDLE_BOTH:     return 6;
      default:       return 0;
    endcase
  endfunction

  task automatic send_beat(logic kind, logic [PORT_W-1:0] port, logic typed,
                           logic [PORT_W-1:0] exp_port, logic exp_full);
    port_result_t r;
    while ($urandom_range(99) < idle_pct(1'b1)) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= port;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = next_port_result(kind, port);
    if (typed) begin
      r.port = exp_port;
      r.full = exp_full;
    end
    awaited_ports.push_back(r);
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (awaited_ports.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_counter(logic [CNT_W-1:0] seed);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    cand_count  = seed;
  endtask

  function automatic logic [PORT_W-1:0] pick_in_use();
    logic [PORT_W-1:0] held [$];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (port_tab[i] != '0) held.push_back(port_tab[i]);
    end
    if (held.size() == 0) return PORT_W'($urandom);
    return held[$urandom_range(held.size() - 1)];
  endfunction

  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= idle_pct(1'b0));
  end

  // result scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (awaited_ports.size() == 0) begin
        $error("result beat with nothing expected: port %h full %b",
               m_axis_tdata_o, m_axis_tuser_o);
        mismatches++;
      end else begin
        got_result = awaited_ports.pop_front();
        if (m_axis_tdata_o !== got_result.port) begin
          $error("allocated_port: expected %h, actual %h", got_result.port, m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tuser_o !== got_result.full) begin
          $error("table_full: expected %b, actual %b", got_result.full, m_axis_tuser_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic              kind;
    logic [PORT_W-1:0] port;
    logic [CNT_W-1:0]  seed;
    int                pick;

    for (int i = 0; i < NUM_SLOTS; i++) port_tab[i] = '0;
    cand_count = '0;

    directed_rows.push_back(mk_row(ROW_BEAT, KIND_ALLOC,   16'h0000, '0, 1'b1, 16'hC000, 1'b0));
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_ALLOC,   16'hFFFF, '0, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_RELEASE, 16'h0000, '0, 1'b1, 16'h0000, 1'b0));
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_RELEASE, 16'hFFFF, '0, 1'b1, 16'h0000, 1'b0));
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_RELEASE, 16'hC000, '0, 1'b1, 16'h0000, 1'b0));
    for (int i = 0; i < 7; i++) begin
      directed_rows.push_back(mk_row(ROW_BEAT, KIND_ALLOC, PORT_W'($urandom), '0, 1'b0, '0,
                                     1'b0));
    end
    // table full, fresh candidate
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_ALLOC,   16'h1234, '0, 1'b1, 16'h0000, 1'b1));
    // full table, eight duplicates before the ninth candidate
    directed_rows.push_back(mk_row(ROW_LOAD, KIND_ALLOC,   '0, 14'h0001, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_ALLOC,   16'h0000, '0, 1'b1, 16'h0000, 1'b1));
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_RELEASE, 16'hC005, '0, 1'b1, 16'h0000, 1'b0));
    directed_rows.push_back(mk_row(ROW_LOAD, KIND_ALLOC,   '0, 14'h3FFF, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_ALLOC,   16'h0000, '0, 1'b1, 16'hFFFF, 1'b0));
    // counter wraps to zero
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_ALLOC,   16'h0000, '0, 1'b1, 16'h0000, 1'b1));
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_RELEASE, 16'hFFFF, '0, 1'b1, 16'h0000, 1'b0));
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_RELEASE, 16'h5555, '0, 1'b1, 16'h0000, 1'b0));
    directed_rows.push_back(mk_row(ROW_BEAT, KIND_ALLOC,   16'hAAAA, '0, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_LOAD, KIND_ALLOC,   '0, 14'h0000, 1'b0, '0, 1'b0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].what == ROW_LOAD) begin
        load_counter(directed_rows[r].seed);
      end else begin
        send_beat(directed_rows[r].kind, directed_rows[r].port, directed_rows[r].typed,
                  directed_rows[r].exp_port, directed_rows[r].exp_full);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      pick = $urandom_range(9);
      if (seg == 0)      seed = '0;
      else if (seg == 1) seed = '1;
      else if (pick < 6) seed = CNT_W'(pick_in_use()) - CNT_W'($urandom_range(3));
      else if (pick < 8) seed = CNT_W'($urandom);
      else               seed = (pick == 8) ? '0 : '1;
      load_counter(seed);
      idle_mode = idle_mode_e'((seg / 4) % 4);
      for (int n = 0; n < SEG_BEATS; n++) begin
        kind = ($urandom_range(99) < 52) ? KIND_ALLOC : KIND_RELEASE;
        pick = $urandom_range(9);
        if (kind == KIND_ALLOC || pick >= 7) port = PORT_W'($urandom);
        else if (pick == 6)                  port = '0;
        else                                 port = pick_in_use();
        send_beat(kind, port, 1'b0, '0, 1'b0);
      end
    end

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && awaited_ports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
